>>> rtl/core/bdb_pkg.sv
// Shared types and constants for the diagonal board checker.
`timescale 1ns / 1ps
package bdb_pkg;
    localparam int unsigned LW = 5;
    localparam int unsigned CW = 2;
    localparam int unsigned SW = 4;

    localparam logic [CW-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CW-1:0] CMD_CONNECT = 2'd1;
    localparam logic [CW-1:0] CMD_TEST    = 2'd2;
    localparam logic [CW-1:0] CMD_CHECK   = 2'd3;

    typedef struct packed {
        logic [CW-1:0] command;
        logic [SW-1:0] crib_slot;
        logic [LW-1:0] from_bundle;
        logic [LW-1:0] to_bundle;
        logic [LW-1:0] letter_in;
        logic [LW-1:0] letter_out;
        logic [LW-1:0] test_bundle;
        logic [LW-1:0] test_wire;
    } t_bdb_in;

    typedef struct packed {
        logic [LW-1:0] live_count;
        logic          consistent;
        logic          stop_found;
        logic [LW-1:0] stop_bundle;
        logic [LW-1:0] stop_wire;
    } t_bdb_out;
endpackage

>>> rtl/core/bdb_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module bdb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/bombe_diagonal_board_check.sv
// Diagonal board with scrambler links, flood test and stop search.
// Clear and connect: result strobe in the cycle after the transfer, busy stays low.
// Test: seed the wire, flood in passes over every slot and letter until a pass changes nothing (at least 1), count.
// Check all: one test per hypothesis tried, bundle major, until the first stop.
// Each flood step reads one permutation entry from the RAM and updates the board.
// Synchronous active-low reset clears board, loaded marks and control; result never stalls.
`timescale 1ns / 1ps
module bombe_diagonal_board_check #(
    parameter int unsigned LETTERS  = 26,
    parameter int unsigned MAX_CRIB = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  bdb_pkg::t_bdb_in i_cmd,
    output logic             busy,
    output logic             o_done,
    output bdb_pkg::t_bdb_out o_result
);
    import bdb_pkg::*;

    localparam int unsigned DEPTH = MAX_CRIB * LETTERS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SLW   = (MAX_CRIB > 1) ? $clog2(MAX_CRIB) : 1;
    localparam int unsigned SXW   = ((SLW > SW) ? SLW : SW) + 1;
    localparam int unsigned PCW   = LW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_FRD  = 3'd2;
    localparam logic [2:0] S_FEV  = 3'd3;
    localparam logic [2:0] S_CNT  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [LETTERS-1:0] r_live [LETTERS];
    logic [LETTERS-1:0] n_live [LETTERS];
    logic [LETTERS-1:0] r_loaded [MAX_CRIB];
    logic [LETTERS-1:0] n_loaded [MAX_CRIB];
    logic [2*LW-1:0]    r_ends [MAX_CRIB];
    logic               r_all, n_all;
    logic [LW-1:0]      r_tb, n_tb, r_tw, n_tw;
    logic [SLW-1:0]     r_slot, n_slot;
    logic [LW-1:0]      r_let, n_let;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_chg, n_chg;
    logic               r_done, n_done;
    t_bdb_out           r_res, n_res;

    logic [SXW-1:0]     slot_x;
    logic               conn_ok;
    logic               ram_we;
    logic [AW-1:0]      waddr;
    logic [LW-1:0]      perm_o;
    logic [LW-1:0]      end_f, end_t;
    logic [PCW-1:0]     pop;
    logic               step_on;
    logic               lit_a, lit_c;

    assign slot_x  = SXW'(i_cmd.crib_slot);
    assign conn_ok = (slot_x < SXW'(MAX_CRIB))
                  && ({1'b0, i_cmd.from_bundle} < PCW'(LETTERS))
                  && ({1'b0, i_cmd.to_bundle} < PCW'(LETTERS))
                  && ({1'b0, i_cmd.letter_in} < PCW'(LETTERS))
                  && ({1'b0, i_cmd.letter_out} < PCW'(LETTERS));
    assign ram_we  = start && !busy && (i_cmd.command == CMD_CONNECT) && conn_ok;
    assign waddr   = AW'(AW'(i_cmd.crib_slot) * AW'(LETTERS) + AW'(i_cmd.letter_in));

    bdb_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.letter_out),
        .i_raddr (r_addr),
        .o_rdata (perm_o)
    );

    assign end_f   = r_ends[r_slot][LW-1:0];
    assign end_t   = r_ends[r_slot][2*LW-1:LW];
    assign step_on = r_loaded[r_slot][r_let]
                  && ({1'b0, end_f} < PCW'(LETTERS))
                  && ({1'b0, end_t} < PCW'(LETTERS))
                  && ({1'b0, perm_o} < PCW'(LETTERS));
    assign lit_a   = step_on && r_live[end_f][r_let];
    assign lit_c   = step_on && r_live[end_t][perm_o];

    always_comb begin
        pop = '0;
        for (int k = 0; k < LETTERS; k++) begin
            pop = pop + PCW'(r_live[r_tb][k]);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_live   = r_live;
        n_loaded = r_loaded;
        n_all    = r_all;
        n_tb     = r_tb;
        n_tw     = r_tw;
        n_slot   = r_slot;
        n_let    = r_let;
        n_addr   = r_addr;
        n_chg    = r_chg;
        n_done   = 1'b0;
        n_res    = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_cmd.command)
                        CMD_CLEAR: begin
                            for (int b = 0; b < LETTERS; b++) n_live[b] = '0;
                            for (int s = 0; s < MAX_CRIB; s++) n_loaded[s] = '0;
                            n_res  = '0;
                            n_done = 1'b1;
                        end
                        CMD_CONNECT: begin
                            if (conn_ok) begin
                                n_loaded[slot_x[SLW-1:0]][i_cmd.letter_in] = 1'b1;
                            end
                            n_res  = '0;
                            n_done = 1'b1;
                        end
                        CMD_TEST: begin
                            n_all   = 1'b0;
                            n_tb    = i_cmd.test_bundle;
                            n_tw    = i_cmd.test_wire;
                            n_state = S_TEST;
                        end
                        default: begin
                            n_all   = 1'b1;
                            n_tb    = '0;
                            n_tw    = '0;
                            n_state = S_TEST;
                        end
                    endcase
                end
            end
            S_TEST: begin
                for (int b = 0; b < LETTERS; b++) n_live[b] = '0;
                if (({1'b0, r_tb} < PCW'(LETTERS)) && ({1'b0, r_tw} < PCW'(LETTERS))) begin
                    n_live[r_tb][r_tw] = 1'b1;
                    n_live[r_tw][r_tb] = 1'b1;
                    n_slot  = '0;
                    n_let   = '0;
                    n_addr  = '0;
                    n_chg   = 1'b0;
                    n_state = S_FRD;
                end else begin
                    n_res   = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FRD: begin
                n_state = S_FEV;
            end
            S_FEV: begin
                if (lit_a != lit_c) begin
                    n_live[end_f][r_let]  = 1'b1;
                    n_live[r_let][end_f]  = 1'b1;
                    n_live[end_t][perm_o] = 1'b1;
                    n_live[perm_o][end_t] = 1'b1;
                    n_chg = 1'b1;
                end
                n_addr  = r_addr + AW'(1);
                n_state = S_FRD;
                if (r_let == LW'(LETTERS - 1)) begin
                    n_let = '0;
                    if (r_slot == SLW'(MAX_CRIB - 1)) begin
                        n_slot = '0;
                        n_addr = '0;
                        if (r_chg || (lit_a != lit_c)) begin
                            n_chg = 1'b0;
                        end else begin
                            n_state = S_CNT;
                        end
                    end else begin
                        n_slot = r_slot + SLW'(1);
                    end
                end else begin
                    n_let = r_let + LW'(1);
                end
            end
            S_CNT: begin
                if (!r_all) begin
                    n_res             = '0;
                    n_res.live_count  = pop[LW-1:0];
                    n_res.consistent  = (pop <= PCW'(1));
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end else if (pop <= PCW'(1)) begin
                    n_res.live_count  = pop[LW-1:0];
                    n_res.consistent  = 1'b1;
                    n_res.stop_found  = 1'b1;
                    n_res.stop_bundle = r_tb;
                    n_res.stop_wire   = r_tw;
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end else if (r_tw == LW'(LETTERS - 1)) begin
                    n_tw = '0;
                    if (r_tb == LW'(LETTERS - 1)) begin
                        n_res   = '0;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_tb    = r_tb + LW'(1);
                        n_state = S_TEST;
                    end
                end else begin
                    n_tw    = r_tw + LW'(1);
                    n_state = S_TEST;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            for (int b = 0; b < LETTERS; b++) r_live[b] <= '0;
            for (int s = 0; s < MAX_CRIB; s++) r_loaded[s] <= '0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_live   <= n_live;
            r_loaded <= n_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ends[slot_x[SLW-1:0]] <= {i_cmd.to_bundle, i_cmd.from_bundle};
        end
        r_all  <= n_all;
        r_tb   <= n_tb;
        r_tw   <= n_tw;
        r_slot <= n_slot;
        r_let  <= n_let;
        r_addr <= n_addr;
        r_chg  <= n_chg;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FEV) |-> ($past(r_state) == S_FRD))
        else $error("flood evaluate without a preceding read");
    a_stop_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.stop_found) |-> o_result.consistent)
        else $error("stop reported without consistency");
    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.command == CMD_TEST || i_cmd.command == CMD_CHECK))
        |=> busy)
        else $error("test transfer did not raise busy");
`endif
endmodule

>>> tb/tb_bombe_diagonal_board_check.sv
// Testbench for the diagonal board checker: directed and random commands against a scoreboard predictor.
`timescale 1ns / 1ps
module tb_bombe_diagonal_board_check;
    import bdb_pkg::*;

    localparam int NL = 26;
    localparam int NS = 16;
    localparam int IW = $bits(t_bdb_in);
    localparam longint CYCLE_LIMIT = 20_000_000;

    class bdb_scoreboard;
        bit [NL-1:0] live_rows[NL];
        bit [4:0]    perm[NS][NL];
        bit [4:0]    from_b[NS];
        bit [4:0]    to_b[NS];
        bit [NL-1:0] loaded[NS];
        t_bdb_out    pending[$];
        int          errors;
        int          checked;

        function new();
            errors  = 0;
            checked = 0;
            foreach (live_rows[b]) live_rows[b] = '0;
            foreach (loaded[s]) loaded[s] = '0;
        endfunction

        function void light(int b, int w);
            live_rows[b][w] = 1'b1;
            live_rows[w][b] = 1'b1;
        endfunction

        function int flood_count(int b, int w);
            bit changed;
            int f;
            int t;
            int o;
            int n;
            foreach (live_rows[k]) live_rows[k] = '0;
            if (b >= NL || w >= NL) return 0;
            light(b, w);
            changed = 1'b1;
            while (changed) begin
                changed = 1'b0;
                for (int s = 0; s < NS; s++) begin
                    f = from_b[s];
                    t = to_b[s];
                    for (int i = 0; i < NL; i++) begin
                        if (!loaded[s][i]) continue;
                        o = perm[s][i];
                        if (f >= NL || t >= NL || o >= NL) continue;
                        if (live_rows[f][i] != live_rows[t][o]) begin
                            light(f, i);
                            light(t, o);
                            changed = 1'b1;
                        end
                    end
                end
            end
            n = 0;
            for (int k = 0; k < NL; k++) n += live_rows[b][k];
            return n;
        endfunction

        function void note(t_bdb_in c);
            t_bdb_out r;
            int n;
            r = '0;
            case (c.command)
                CMD_CLEAR: begin
                    foreach (live_rows[k]) live_rows[k] = '0;
                    foreach (loaded[s]) loaded[s] = '0;
                end
                CMD_CONNECT: begin
                    if (c.from_bundle < NL && c.to_bundle < NL &&
                        c.letter_in < NL && c.letter_out < NL) begin
                        perm[c.crib_slot][c.letter_in] = c.letter_out;
                        from_b[c.crib_slot] = c.from_bundle;
                        to_b[c.crib_slot]   = c.to_bundle;
                        loaded[c.crib_slot][c.letter_in] = 1'b1;
                    end
                end
                CMD_TEST: begin
                    n = flood_count(c.test_bundle, c.test_wire);
                    if (c.test_bundle < NL && c.test_wire < NL) begin
                        r.live_count = n[4:0];
                        r.consistent = (n <= 1);
                    end
                end
                default: begin
                    for (int b = 0; b < NL && !r.stop_found; b++) begin
                        for (int w = 0; w < NL; w++) begin
                            n = flood_count(b, w);
                            if (n <= 1) begin
                                r.stop_found  = 1'b1;
                                r.live_count  = n[4:0];
                                r.stop_bundle = b[4:0];
                                r.stop_wire   = w[4:0];
                                break;
                            end
                        end
                    end
                    r.consistent = r.stop_found;
                end
            endcase
            pending.insert(pending.size(), r);
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("mismatch on result %0d: %s got %0d want %0d", checked, what, got, want);
        endtask

        task check(t_bdb_out r);
            t_bdb_out e;
            if (pending.size() == 0) begin
                report("unexpected result strobe", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (r.live_count !== e.live_count) report("live_count", r.live_count, e.live_count);
            if (r.consistent !== e.consistent) report("consistent", r.consistent, e.consistent);
            if (r.stop_found !== e.stop_found) report("stop_found", r.stop_found, e.stop_found);
            if (r.stop_bundle !== e.stop_bundle)
                report("stop_bundle", r.stop_bundle, e.stop_bundle);
            if (r.stop_wire !== e.stop_wire) report("stop_wire", r.stop_wire, e.stop_wire);
            checked++;
        endtask
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_bdb_in  i_cmd;
    logic     busy;
    logic     o_done;
    t_bdb_out o_result;

    bdb_scoreboard sb;
    longint        cycles;
    int            cmd_seen[4];
    int            links_since_clear;
    bit            idle_ok;

    bombe_diagonal_board_check u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check(o_result);
    end

    function t_bdb_in random_item();
        return t_bdb_in'(IW'({$urandom, $urandom}));
    endfunction

    task send(t_bdb_in c);
        @(negedge i_clk);
        while (idle_ok && $urandom_range(0, 99) < 25) begin
            start = 1'b0;
            i_cmd = random_item();
            @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = c;
        do @(posedge i_clk); while (busy);
        sb.note(c);
        cmd_seen[c.command]++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task send_clear();
        t_bdb_in c;
        c = random_item();
        c.command = CMD_CLEAR;
        links_since_clear = 0;
        send(c);
    endtask

    task send_link(int slot, int fb, int tb, int li, int lo);
        t_bdb_in c;
        c = random_item();
        c.command     = CMD_CONNECT;
        c.crib_slot   = slot[3:0];
        c.from_bundle = fb[4:0];
        c.to_bundle   = tb[4:0];
        c.letter_in   = li[4:0];
        c.letter_out  = lo[4:0];
        links_since_clear++;
        send(c);
    endtask

    task send_test(int b, int w);
        t_bdb_in c;
        c = random_item();
        c.command     = CMD_TEST;
        c.test_bundle = b[4:0];
        c.test_wire   = w[4:0];
        send(c);
    endtask

    task send_check();
        t_bdb_in c;
        c = random_item();
        c.command = CMD_CHECK;
        send(c);
    endtask

    function int pick_letter();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(0, NL - 1);
    endfunction

    initial begin
        int roll;
        int wait_n;
        sb      = new();
        cycles  = 0;
        idle_ok = 1'b1;
        links_since_clear = 0;
        foreach (cmd_seen[k]) cmd_seen[k] = 0;
        start   = 1'b0;
        i_cmd   = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_check();
        send_test(0, 0);
        send_test(25, 25);
        send_test(26, 3);
        send_test(4, 31);
        send_link(0, 0, 0, 0, 1);
        send_check();
        send_test(0, 0);
        send_link(15, 25, 1, 25, 0);
        send_link(15, 2, 3, 25, 25);
        send_link(3, 31, 2, 1, 1);
        send_link(3, 2, 26, 1, 1);
        send_link(3, 2, 2, 30, 1);
        send_link(3, 2, 2, 1, 31);
        send_link(7, 1, 0, 5, 9);
        send_test(0, 1);
        send_test(25, 2);
        send_test(3, 25);
        send_test(31, 31);
        send_clear();
        send_test(0, 1);
        send_link(1, 5, 5, 5, 5);
        send_check();

        for (int n = 0; n < 1700; n++) begin
            idle_ok = !(n >= 600 && n < 900);
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                send_clear();
            end else if (roll < 6 && links_since_clear <= 3) begin
                send_check();
            end else if (roll < 14) begin
                send_test(pick_letter(), pick_letter());
            end else begin
                send_link($urandom_range(0, NS - 1), pick_letter(), pick_letter(),
                          pick_letter(), pick_letter());
            end
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        wait_n = 0;
        while (wait_n < 50 || busy) begin
            @(posedge i_clk);
            wait_n++;
        end

        $display("covered %0d clears, %0d connects, %0d tests, %0d stop searches",
                 cmd_seen[CMD_CLEAR], cmd_seen[CMD_CONNECT], cmd_seen[CMD_TEST],
                 cmd_seen[CMD_CHECK]);
        $display("%0d results compared in %0d cycles", sb.checked, cycles);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
